>>> rtl/via_pkg.sv
// ----------------------------------------------------------------------------
// via_pkg: shared types and constants of the VM integer ALU
// Operation codes, word sizes and the control record that travels with a beat.
// ----------------------------------------------------------------------------
package via_pkg;

	localparam int XLEN           = 64;
	localparam int WORD_WIDTH_DEF = 64;

	typedef enum logic [4:0] {
		OP_BNOT = 5'd0,
		OP_BAND = 5'd1,
		OP_BXOR = 5'd2,
		OP_BOR  = 5'd3,
		OP_SHL  = 5'd4,
		OP_SHR  = 5'd5,
		OP_INC  = 5'd6,
		OP_DEC  = 5'd7,
		OP_POW  = 5'd8,
		OP_ADD  = 5'd9,
		OP_SUB  = 5'd10,
		OP_MUL  = 5'd11,
		OP_DIV  = 5'd12,
		OP_REM  = 5'd13,
		OP_NEG  = 5'd14,
		OP_EQ   = 5'd15,
		OP_NE   = 5'd16,
		OP_LT   = 5'd17,
		OP_LE   = 5'd18,
		OP_GT   = 5'd19,
		OP_GE   = 5'd20,
		OP_LNOT = 5'd21,
		OP_LAND = 5'd22,
		OP_LOR  = 5'd23,
		OP_MOV  = 5'd24
	} op_t;

	typedef struct packed {
		op_t  op;
		logic a_neg;
		logic b_neg;
		logic div0;
	} ctl_t;

endpackage

>>> rtl/vm_integer_alu.sv
// ----------------------------------------------------------------------------
// vm_integer_alu: pipelined integer ALU of a bytecode virtual machine
// Wrapping WORD_WIDTH-bit arithmetic, logic, compare, power and divide.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one beat: action, operand_a,
//   operand_b. Output channel (out_valid/out_ready) returns result and fault.
//   Only the low WORD_WIDTH bits of each operand are used; result is the
//   WORD_WIDTH-bit value sign-extended to 64 bits.
//   Throughput: one beat per cycle while the receiver keeps out_ready high, every operation alike.
//   Pipeline: the power and divide chain has WORD_WIDTH steps of two
//   stages, each step handling one exponent bit (two split multiplies)
//   and one restoring quotient bit. The front end adds three stages
//   (capture, decode, product sum), the back end one output register.
//   Stall: every stage holds its beat while its successor is full and not
//   advancing; empty stages keep filling, so in_ready drops only once the
//   whole pipe is full behind a stalled receiver.
//   Reset: arst_n clears all valid bits; the pipe comes up empty.
// ----------------------------------------------------------------------------
module vm_integer_alu import via_pkg::*; #(
	parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [4:0]      action,
	input  logic [XLEN-1:0] operand_a,
	input  logic [XLEN-1:0] operand_b,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [XLEN-1:0] result,
	output logic            fault
);

	localparam int W = WORD_WIDTH;

	// chain links: index 0 is the front end output, index W the last step
	logic         v_c     [W+1];
	logic         rdy_c   [W+1];
	ctl_t         ctl_c   [W+1];
	logic [W-1:0] simple_c[W+1];
	logic [W-1:0] r_c     [W+1];
	logic [W-1:0] base_c  [W+1];
	logic [W-1:0] exp_c   [W+1];
	logic [W-1:0] rem_c   [W+1];
	logic [W-1:0] quo_c   [W+1];
	logic [W-1:0] den_c   [W+1];

	via_front #(.W(W)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.out_valid (v_c[0]),
		.out_ready (rdy_c[0]),
		.ctl       (ctl_c[0]),
		.simple    (simple_c[0]),
		.pow_base  (base_c[0]),
		.pow_exp   (exp_c[0]),
		.div_quo   (quo_c[0]),
		.div_den   (den_c[0])
	);

	// power starts from one, divide from a zero partial remainder
	assign r_c[0]   = W'(1);
	assign rem_c[0] = '0;

	for (genvar i = 0; i < W; i++) begin : g_step
		via_step #(.W(W)) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (v_c[i]),
			.in_ready  (rdy_c[i]),
			.ctl_i     (ctl_c[i]),
			.simple_i  (simple_c[i]),
			.r_i       (r_c[i]),
			.base_i    (base_c[i]),
			.exp_i     (exp_c[i]),
			.rem_i     (rem_c[i]),
			.quo_i     (quo_c[i]),
			.den_i     (den_c[i]),
			.out_valid (v_c[i+1]),
			.out_ready (rdy_c[i+1]),
			.ctl_o     (ctl_c[i+1]),
			.simple_o  (simple_c[i+1]),
			.r_o       (r_c[i+1]),
			.base_o    (base_c[i+1]),
			.exp_o     (exp_c[i+1]),
			.rem_o     (rem_c[i+1]),
			.quo_o     (quo_c[i+1]),
			.den_o     (den_c[i+1])
		);
	end

	via_back #(.W(W)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_c[W]),
		.in_ready  (rdy_c[W]),
		.ctl       (ctl_c[W]),
		.simple    (simple_c[W]),
		.pow_r     (r_c[W]),
		.quo       (quo_c[W]),
		.rem       (rem_c[W]),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result    (result),
		.fault     (fault)
	);

endmodule

>>> rtl/via_front.sv
// ----------------------------------------------------------------------------
// via_front: operand capture, simple operations and the plain multiply
// Three register stages: capture, decode with partial products, product sum.
// ----------------------------------------------------------------------------
module via_front import via_pkg::*; #(
	parameter int W = WORD_WIDTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [4:0]      action,
	input  logic [XLEN-1:0] operand_a,
	input  logic [XLEN-1:0] operand_b,
	output logic            out_valid,
	input  logic            out_ready,
	output ctl_t            ctl,
	output logic [W-1:0]    simple,
	output logic [W-1:0]    pow_base,
	output logic [W-1:0]    pow_exp,
	output logic [W-1:0]    div_quo,
	output logic [W-1:0]    div_den
);

	localparam int H  = W / 2;
	localparam int L  = W - H;
	localparam int SW = $clog2(W);
	localparam logic [W-1:0] W_VAL = W'(W);

	logic            v_s1, v_s2, v_s3;
	logic            rdy1, rdy2, rdy3;
	op_t             op_s1;
	logic [W-1:0]    a_s1, b_s1;

	ctl_t            ctl_s2, ctl_s3;
	logic [W-1:0]    simple_s2, a_s2, b_s2, ua_s2, ub_s2;
	logic [2*H-1:0]  p0_s2;
	logic [L-1:0]    p1_s2, p2_s2;
	logic [W-1:0]    simple_s3, a_s3, b_s3, ua_s3, ub_s3;

	logic [W-1:0]    simple_c, ua_c, ub_c, prod_c;
	logic            in_range, lt, gt;
	logic [SW-1:0]   sh;
	logic [2*H-1:0]  p0_c;
	logic [H+L-1:0]  f1_c, f2_c;
	ctl_t            ctl_c;

	assign rdy3     = !v_s3 || out_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	// decode and simple operations
	assign in_range = !b_s1[W-1] && (b_s1 < W_VAL);
	assign sh       = b_s1[SW-1:0];
	assign lt       = $signed(a_s1) < $signed(b_s1);
	assign gt       = $signed(b_s1) < $signed(a_s1);

	always_comb begin
		case (op_s1)
			OP_BNOT: simple_c = ~a_s1;
			OP_BAND: simple_c = a_s1 & b_s1;
			OP_BXOR: simple_c = a_s1 ^ b_s1;
			OP_BOR:  simple_c = a_s1 | b_s1;
			OP_SHL:  simple_c = in_range ? (a_s1 << sh) : '0;
			OP_SHR:  simple_c = in_range ? W'($signed(a_s1) >>> sh) : {W{a_s1[W-1]}};
			OP_INC:  simple_c = a_s1 + W'(1);
			OP_DEC:  simple_c = a_s1 - W'(1);
			OP_ADD:  simple_c = a_s1 + b_s1;
			OP_SUB:  simple_c = a_s1 - b_s1;
			OP_NEG:  simple_c = '0 - a_s1;
			OP_EQ:   simple_c = W'(a_s1 == b_s1);
			OP_NE:   simple_c = W'(a_s1 != b_s1);
			OP_LT:   simple_c = W'(lt);
			OP_LE:   simple_c = W'(!gt);
			OP_GT:   simple_c = W'(gt);
			OP_GE:   simple_c = W'(!lt);
			OP_LNOT: simple_c = W'(a_s1 == '0);
			OP_LAND: simple_c = W'((a_s1 != '0) && (b_s1 != '0));
			OP_LOR:  simple_c = W'((a_s1 != '0) || (b_s1 != '0));
			OP_MOV:  simple_c = b_s1;
			OP_POW, OP_MUL, OP_DIV, OP_REM: simple_c = '0;
			default: simple_c = a_s1;
		endcase
	end

	assign ua_c = a_s1[W-1] ? ('0 - a_s1) : a_s1;
	assign ub_c = b_s1[W-1] ? ('0 - b_s1) : b_s1;

	// partial products of the low word of a * b
	assign p0_c = a_s1[H-1:0] * b_s1[H-1:0];
	assign f1_c = a_s1[H-1:0] * b_s1[W-1:H];
	assign f2_c = a_s1[W-1:H] * b_s1[H-1:0];

	assign ctl_c.op    = op_s1;
	assign ctl_c.a_neg = a_s1[W-1];
	assign ctl_c.b_neg = b_s1[W-1];
	assign ctl_c.div0  = (b_s1 == '0);

	assign prod_c = W'(p0_s2) + {L'(p1_s2 + p2_s2), {H{1'b0}}};

	always_ff @(posedge clk) begin
		if (rdy1) begin
			op_s1 <= op_t'(action);
			a_s1  <= operand_a[W-1:0];
			b_s1  <= operand_b[W-1:0];
		end
		if (rdy2) begin
			ctl_s2    <= ctl_c;
			simple_s2 <= simple_c;
			a_s2      <= a_s1;
			b_s2      <= b_s1;
			ua_s2     <= ua_c;
			ub_s2     <= ub_c;
			p0_s2     <= p0_c;
			p1_s2     <= f1_c[L-1:0];
			p2_s2     <= f2_c[L-1:0];
		end
		if (rdy3) begin
			ctl_s3    <= ctl_s2;
			simple_s3 <= (ctl_s2.op == OP_MUL) ? prod_c : simple_s2;
			a_s3      <= a_s2;
			b_s3      <= b_s2;
			ua_s3     <= ua_s2;
			ub_s3     <= ub_s2;
		end
	end

	assign out_valid = v_s3;
	assign ctl       = ctl_s3;
	assign simple    = simple_s3;
	assign pow_base  = a_s3;
	assign pow_exp   = b_s3;
	assign div_quo   = ua_s3;
	assign div_den   = ub_s3;

endmodule

>>> rtl/via_step.sv
// ----------------------------------------------------------------------------
// via_step: one exponent bit of the power and one quotient bit of the divide
// Two register stages: partial products plus divide bit, then product sums.
// ----------------------------------------------------------------------------
module via_step import via_pkg::*; #(
	parameter int W = WORD_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  ctl_t         ctl_i,
	input  logic [W-1:0] simple_i,
	input  logic [W-1:0] r_i,
	input  logic [W-1:0] base_i,
	input  logic [W-1:0] exp_i,
	input  logic [W-1:0] rem_i,
	input  logic [W-1:0] quo_i,
	input  logic [W-1:0] den_i,
	output logic         out_valid,
	input  logic         out_ready,
	output ctl_t         ctl_o,
	output logic [W-1:0] simple_o,
	output logic [W-1:0] r_o,
	output logic [W-1:0] base_o,
	output logic [W-1:0] exp_o,
	output logic [W-1:0] rem_o,
	output logic [W-1:0] quo_o,
	output logic [W-1:0] den_o
);

	localparam int H = W / 2;
	localparam int L = W - H;

	logic           v_s1, v_s2, rdy1, rdy2;
	ctl_t           ctl_s1, ctl_s2;
	logic [W-1:0]   simple_s1, r_s1, exp_s1, rem_s1, quo_s1, den_s1;
	logic [2*H-1:0] rb0_s1, bb0_s1;
	logic [L-1:0]   rb1_s1, rb2_s1, bb1_s1, bb2_s1;
	logic [W-1:0]   simple_s2, r_s2, base_s2, exp_s2, rem_s2, quo_s2, den_s2;

	logic [2*H-1:0] rb0_c, bb0_c;
	logic [H+L-1:0] rb1_c, rb2_c, bb1_c, bb2_c;
	logic [W:0]     t_c, diff_c;
	logic           ge_c;

	assign rdy2     = !v_s2 || out_ready;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
		end
	end

	assign rb0_c = r_i[H-1:0] * base_i[H-1:0];
	assign rb1_c = r_i[H-1:0] * base_i[W-1:H];
	assign rb2_c = r_i[W-1:H] * base_i[H-1:0];
	assign bb0_c = base_i[H-1:0] * base_i[H-1:0];
	assign bb1_c = base_i[H-1:0] * base_i[W-1:H];
	assign bb2_c = base_i[W-1:H] * base_i[H-1:0];

	// restoring divide: shift in the next dividend bit, subtract when it fits
	assign t_c    = {rem_i, quo_i[W-1]};
	assign diff_c = t_c - {1'b0, den_i};
	assign ge_c   = t_c >= {1'b0, den_i};

	always_ff @(posedge clk) begin
		if (rdy1) begin
			ctl_s1    <= ctl_i;
			simple_s1 <= simple_i;
			r_s1      <= r_i;
			exp_s1    <= exp_i;
			den_s1    <= den_i;
			rem_s1    <= ge_c ? diff_c[W-1:0] : t_c[W-1:0];
			quo_s1    <= {quo_i[W-2:0], ge_c};
			rb0_s1    <= rb0_c;
			rb1_s1    <= rb1_c[L-1:0];
			rb2_s1    <= rb2_c[L-1:0];
			bb0_s1    <= bb0_c;
			bb1_s1    <= bb1_c[L-1:0];
			bb2_s1    <= bb2_c[L-1:0];
		end
		if (rdy2) begin
			ctl_s2    <= ctl_s1;
			simple_s2 <= simple_s1;
			rem_s2    <= rem_s1;
			quo_s2    <= quo_s1;
			den_s2    <= den_s1;
			exp_s2    <= exp_s1 >> 1;
			base_s2   <= W'(bb0_s1) + {L'(bb1_s1 + bb2_s1), {H{1'b0}}};
			r_s2      <= exp_s1[0] ? (W'(rb0_s1) + {L'(rb1_s1 + rb2_s1), {H{1'b0}}})
			                       : r_s1;
		end
	end

	assign out_valid = v_s2;
	assign ctl_o     = ctl_s2;
	assign simple_o  = simple_s2;
	assign r_o       = r_s2;
	assign base_o    = base_s2;
	assign exp_o     = exp_s2;
	assign rem_o     = rem_s2;
	assign quo_o     = quo_s2;
	assign den_o     = den_s2;

endmodule

>>> rtl/via_back.sv
// ----------------------------------------------------------------------------
// via_back: result select, divide sign fix and output register
// Applies quotient and remainder signs, zero-divisor and negative-power rules.
// ----------------------------------------------------------------------------
module via_back import via_pkg::*; #(
	parameter int W = WORD_WIDTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ctl_t            ctl,
	input  logic [W-1:0]    simple,
	input  logic [W-1:0]    pow_r,
	input  logic [W-1:0]    quo,
	input  logic [W-1:0]    rem,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [XLEN-1:0] result,
	output logic            fault
);

	logic            valid_q, fault_q, fault_c;
	logic [W-1:0]    res_q, res_c;

	assign in_ready = !valid_q || out_ready;

	always_comb begin
		case (ctl.op)
			OP_POW:  res_c = ctl.b_neg ? W'(1) : pow_r;
			OP_DIV:  res_c = ctl.div0 ? '0 :
			                 ((ctl.a_neg ^ ctl.b_neg) ? ('0 - quo) : quo);
			OP_REM:  res_c = ctl.div0 ? '0 : (ctl.a_neg ? ('0 - rem) : rem);
			default: res_c = simple;
		endcase
	end

	assign fault_c = ((ctl.op == OP_DIV) || (ctl.op == OP_REM)) && ctl.div0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			res_q   <= res_c;
			fault_q <= fault_c;
		end
	end

	assign out_valid = valid_q;
	assign result    = XLEN'($signed(res_q));
	assign fault     = fault_q;

endmodule
